// ----- sv/amph_pkg.sv -----
package amph_pkg;

  // Queue between the front and the back
  localparam int QueueDepth = 2;

  // Field and datapath widths
  localparam int AccelW  = 16;
  localparam int OneGW   = 12;
  localparam int ClampW  = 15;
  localparam int HoldW   = 8;
  localparam int ValW    = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 15;
  localparam int RootW   = 20;
  localparam int QuotW   = 7;

  // Register reset values
  localparam logic [OneGW-1:0]  OneGReset  = 12'd1044;
  localparam logic [ClampW-1:0] ClampReset = 15'd4095;
  localparam logic [HoldW-1:0]  HoldReset  = 8'd15;

  // Saturation bounds of the result
  localparam logic signed [ValW-1:0] ValMax = 8'sd127;
  localparam logic signed [ValW-1:0] ValMin = -8'sd128;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgOneG  = 2'd0,
    CfgClamp = 2'd1,
    CfgHold  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [OneGW-1:0]  one_g;
    logic [ClampW-1:0] clamp_limit;
    logic [HoldW-1:0]  hold_period;
  } cfg_regs_t;

  // One classified sample, as queued for the back end
  typedef struct packed {
    logic signed [AccelW-1:0] x;
    logic signed [AccelW-1:0] y;
    logic signed [AccelW-1:0] z;
    logic                     hold_clear;
    logic                     drop;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- sv/amph_if.sv -----
interface sample_if import amph_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [AccelW-1:0] accel_x;
  logic signed [AccelW-1:0] accel_y;
  logic signed [AccelW-1:0] accel_z;
  logic                     vibrating;

  modport source (output valid, accel_x, accel_y, accel_z, vibrating, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, vibrating, output ready);
endinterface

interface result_if import amph_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] dynamic_accel;
  logic signed [ValW-1:0] peak_max;
  logic signed [ValW-1:0] peak_min;

  modport source (output valid, dynamic_accel, peak_max, peak_min, input ready);
  modport sink (input valid, dynamic_accel, peak_max, peak_min, output ready);
endinterface

interface cfg_if import amph_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/amph_front.sv -----
module amph_front import amph_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sample_if.sink    sample,
  input  cfg_regs_t cfg_regs,
  input  q_status_t q_status,
  output logic      q_push,
  output q_entry_t  q_entry
);

  logic [HoldW-1:0]          hold_counter;
  logic [HoldW-1:0]          hold_counter_next;
  logic                      hold_clear;
  logic signed [AccelW:0]    lim_pos;
  logic signed [AccelW:0]    lim_neg;

  function automatic logic signed [AccelW-1:0] clamp_axis(
    input logic signed [AccelW-1:0] v,
    input logic signed [AccelW:0]   hi,
    input logic signed [AccelW:0]   lo
  );
    logic signed [AccelW:0] ext;
    ext = {v[AccelW-1], v};
    if (ext > hi) begin
      return hi[AccelW-1:0];
    end else if (ext < lo) begin
      return lo[AccelW-1:0];
    end
    return v;
  endfunction

  // Symmetric clamp bounds
  assign lim_pos = $signed({2'b00, cfg_regs.clamp_limit});
  assign lim_neg = -lim_pos;

  // Take a beat whenever the queue has room
  assign sample.ready = !q_status.full;
  assign q_push       = sample.valid && sample.ready;

  // Hold counter runs on every beat, vibrating or not
  assign hold_clear        = hold_counter > cfg_regs.hold_period;
  assign hold_counter_next = hold_clear ? '0 : hold_counter + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_counter <= '0;
    end else if (q_push) begin
      hold_counter <= hold_counter_next;
    end
  end

  // Classify and clamp the beat for the back end
  always_comb begin
    q_entry.x          = clamp_axis(sample.accel_x, lim_pos, lim_neg);
    q_entry.y          = clamp_axis(sample.accel_y, lim_pos, lim_neg);
    q_entry.z          = clamp_axis(sample.accel_z, lim_pos, lim_neg);
    q_entry.hold_clear = hold_clear;
    q_entry.drop       = sample.vibrating;
  end

endmodule

// ----- sv/amph_queue.sv -----
module amph_queue import amph_pkg::*; #(
  parameter int Depth = QueueDepth  // at least 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  pop_entry,
  output q_status_t status
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  q_entry_t          entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign pop_entry    = entries[rd_ptr];
  assign status.full  = count == CntW'(Depth);
  assign status.empty = count == '0;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/amph_back.sv -----
module amph_back import amph_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg_regs,
  input  q_status_t q_status,
  input  q_entry_t  q_entry,
  output logic      q_pop,
  result_if.source  result
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQUARE, S_ROOT, S_SUB, S_MUL, S_DIVCHK, S_DIV, S_DONE
  } state_t;

  state_t                   state;
  logic signed [AccelW-1:0] ax, ay, az;
  logic [1:0]               sq_cnt;
  logic [31:0]              acc;
  logic [39:0]              rad;
  logic [20:0]              rem;
  logic [RootW-1:0]         root;
  logic [4:0]               step;
  logic signed [21:0]       diff;
  logic [29:0]              mag;
  logic                     neg;
  logic                     sat;
  logic [29:0]              dr;
  logic [24:0]              dv;
  logic [QuotW-1:0]         quo;
  logic signed [ValW-1:0]   max_hold, min_hold;
  logic                     out_valid;
  logic signed [ValW-1:0]   out_accel, out_max, out_min;

  logic [OneGW-1:0]         g;
  logic [17:0]              denom;
  logic signed [AccelW-1:0] sq_sel;
  logic signed [31:0]       square;
  logic [31:0]              acc_sum;
  logic [22:0]              rem_sh;
  logic [22:0]              trial;
  logic signed [21:0]       diff_c;
  logic signed [30:0]       diff_ext;
  logic signed [30:0]       num_w;
  logic [30:0]              num_abs;
  logic signed [ValW-1:0]   quo_s;
  logic signed [ValW-1:0]   val;
  logic signed [ValW-1:0]   new_max, new_min;
  logic                     out_free;

  // Zero one_g counts as one
  assign g     = (cfg_regs.one_g == '0) ? OneGW'(1) : cfg_regs.one_g;
  assign denom = {g, 6'b0};

  // One squarer, shared across the three axes
  always_comb begin
    unique case (sq_cnt)
      2'd0:    sq_sel = ax;
      2'd1:    sq_sel = ay;
      default: sq_sel = az;
    endcase
  end
  assign square  = sq_sel * sq_sel;
  assign acc_sum = acc + unsigned'(square);

  // One root bit per cycle
  assign rem_sh = {rem, rad[39:38]};
  assign trial  = {1'b0, root, 2'b01};

  // Subtract 16 g, then scale by 261 with shifts and adds
  assign diff_c   = $signed({2'b00, root}) - $signed({6'b0, g, 4'b0});
  assign diff_ext = {{9{diff[21]}}, diff};
  assign num_w    = (diff_ext <<< 8) + (diff_ext <<< 2) + diff_ext;
  assign num_abs  = num_w[30] ? unsigned'(-num_w) : unsigned'(num_w);

  // Signed, saturated quotient and hold update
  assign quo_s = $signed({1'b0, quo});
  always_comb begin
    if (sat) begin
      val = neg ? ValMin : ValMax;
    end else begin
      val = neg ? -quo_s : quo_s;
    end
  end
  assign new_max = (val > max_hold) ? val : max_hold;
  assign new_min = (val < min_hold) ? val : min_hold;

  assign out_free = !out_valid || result.ready;
  assign q_pop    = (state == S_IDLE) && !q_status.empty;

  assign result.valid         = out_valid;
  assign result.dynamic_accel = out_accel;
  assign result.peak_max      = out_max;
  assign result.peak_min      = out_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      max_hold  <= ValMin;
      min_hold  <= ValMax;
    end else begin
      // Drop the output beat once taken
      if (out_valid && result.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        // Pop the next entry; clear holds first if the front asked
        S_IDLE: begin
          if (q_pop) begin
            if (q_entry.hold_clear) begin
              max_hold <= ValMin;
              min_hold <= ValMax;
            end
            ax     <= q_entry.x;
            ay     <= q_entry.y;
            az     <= q_entry.z;
            acc    <= '0;
            sq_cnt <= '0;
            if (!q_entry.drop) begin
              state <= S_SQUARE;
            end
          end
        end

        // Accumulate the sum of squares
        S_SQUARE: begin
          acc    <= acc_sum;
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 2'd2) begin
            rad   <= {acc_sum, 8'b0};
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= S_ROOT;
          end
        end

        // Digit-by-digit square root of S * 256
        S_ROOT: begin
          if (rem_sh >= trial) begin
            rem  <= 21'(rem_sh - trial);
            root <= {root[RootW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh[20:0];
            root <= {root[RootW-2:0], 1'b0};
          end
          rad  <= {rad[37:0], 2'b00};
          step <= step + 1'b1;
          if (step == 5'(RootW - 1)) begin
            state <= S_SUB;
          end
        end

        S_SUB: begin
          diff  <= diff_c;
          state <= S_MUL;
        end

        S_MUL: begin
          mag   <= num_abs[29:0];
          neg   <= num_w[30];
          state <= S_DIVCHK;
        end

        // Saturate when the quotient reaches 128
        S_DIVCHK: begin
          sat   <= mag >= {5'b0, denom, 7'b0};
          dr    <= mag;
          dv    <= {1'b0, denom, 6'b0};
          quo   <= '0;
          step  <= '0;
          state <= S_DIV;
        end

        // Restoring divide, one quotient bit per cycle
        S_DIV: begin
          if (dr >= {5'b0, dv}) begin
            dr  <= dr - {5'b0, dv};
            quo <= {quo[QuotW-2:0], 1'b1};
          end else begin
            quo <= {quo[QuotW-2:0], 1'b0};
          end
          dv   <= {1'b0, dv[24:1]};
          step <= step + 1'b1;
          if (step == 5'(QuotW - 1)) begin
            state <= S_DONE;
          end
        end

        // Update holds and load the output register
        S_DONE: begin
          if (out_free) begin
            max_hold  <= new_max;
            min_hold  <= new_min;
            out_accel <= val;
            out_max   <= new_max;
            out_min   <= new_min;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/accel_magnitude_peak_hold.sv -----
// Accelerometer magnitude meter with min/max hold.
//
// sample: one beat per tick with three signed axes and a vibration flag.
// result: dynamic_accel = (|a| / one_g - 1) * 65.25 saturated to int8, plus the
//   running peak_max and peak_min since the last hold reset.
// cfg: register writes (0 one_g, 1 clamp_limit, 2 hold_period), always ready;
//   write only while the block is idle.
//
// The front end runs the hold counter and clamps each axis at the input beat,
// then queues the entry. Vibrating beats still advance the counter and may
// clear the holds, but produce no result. The back end works one entry at a
// time: a pop, squaring on a shared multiplier, the bit-serial square root,
// scaling (subtract, multiply, divide check), the restoring divider, then
// the load of the output register, which waits while that register is full.
// A vibrating beat leaves the back end after its pop cycle.
// While the receiver stalls the output register holds its beat; the back end
// keeps popping and computing up to the load, and the queue keeps taking beats
// until full. Reset clears the counter, the holds, the queue and the output.
module accel_magnitude_peak_hold import amph_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic     clk,
  input  logic     rst,
  sample_if.sink   sample,
  result_if.source result,
  cfg_if.sink      cfg
);

  cfg_regs_t cfg_regs;
  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  pop_entry;
  logic      q_push;
  logic      q_pop;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.one_g       <= OneGReset;
      cfg_regs.clamp_limit <= ClampReset;
      cfg_regs.hold_period <= HoldReset;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CfgOneG:  cfg_regs.one_g       <= cfg.data[OneGW-1:0];
        CfgClamp: cfg_regs.clamp_limit <= cfg.data[ClampW-1:0];
        CfgHold:  cfg_regs.hold_period <= cfg.data[HoldW-1:0];
        default:  ;
      endcase
    end
  end

  amph_front u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .cfg_regs (cfg_regs),
    .q_status (q_status),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  amph_queue #(.Depth(QDepth)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  amph_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .q_status (q_status),
    .q_entry  (pop_entry),
    .q_pop    (q_pop),
    .result   (result)
  );

  // Output value lies between the holds it was folded into
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ($signed(result.peak_max) >= $signed(result.dynamic_accel)) &&
                     ($signed(result.dynamic_accel) >= $signed(result.peak_min)))
    else $error("result outside its own min/max holds");

  // Magnitude is never negative, so the value never drops below -65
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> $signed(result.dynamic_accel) >= -8'sd65)
    else $error("dynamic_accel below the zero-magnitude floor");

  // Reset empties the queue and the output register
  assert property (@(posedge clk)
    rst |=> !result.valid && q_status.empty)
    else $error("pipeline not empty after reset");

endmodule
